// ----- rtl/mzht_pkg.sv -----
package mzht_pkg;

  localparam int ZONES = 6;
  localparam int ZW = 3;
  localparam logic [15:0] BUMP_LIMIT = 16'd120;
  localparam logic signed [17:0] CIRCUIT_DROP = 18'sd5;
  localparam logic signed [15:0] DEFAULT_TARGET = 16'sd210;
  localparam logic signed [15:0] DEFAULT_TOLERANCE = 16'sd5;
  localparam logic signed [15:0] NO_TEMP = 16'sh8000;
  localparam logic [15:0] DEFAULT_LIFE = 16'd2;

  localparam logic [2:0] FN_TICK = 3'd0;
  localparam logic [2:0] FN_READ = 3'd1;
  localparam logic [2:0] FN_BUMP = 3'd2;
  localparam logic [2:0] FN_MODE = 3'd3;
  localparam logic [2:0] FN_SETP = 3'd4;
  localparam logic [2:0] FN_TOL = 3'd5;

  localparam logic [1:0] CFG_CIRCUIT = 2'd0;
  localparam logic [1:0] CFG_PUMP = 2'd1;
  localparam logic [1:0] CFG_LIFE = 2'd2;

  localparam logic [2:0] RS_NONE = 3'd0;
  localparam logic [2:0] RS_ON_COLD = 3'd1;
  localparam logic [2:0] RS_ON_BUMP = 3'd2;
  localparam logic [2:0] RS_OFF_NOSENS = 3'd3;
  localparam logic [2:0] RS_OFF_HOT = 3'd4;
  localparam logic [2:0] RS_OFF_IDLE = 3'd5;
  localparam logic [2:0] RS_OFF_LIMIT = 3'd6;
  localparam logic [2:0] RS_OFF_WARM = 3'd7;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] zone;
    logic signed [15:0] reading;
    logic heat_mode;
    logic signed [15:0] setpoint;
    logic signed [15:0] band;
  } in_t;

  typedef struct packed {
    logic heater_relay;
    logic circuit_heating;
    logic water_pump;
    logic bump_run;
    logic [2:0] switch_reason;
    logic [5:0] online_mask;
  } out_t;

  // IDLE take request; DEC walk zones (decrement); TREND circuit trend; SCAN walk zones (flags);
  // DECIDE relay; PUMP walk zones for pump; MASK walk zones for online mask; DONE hold result
  typedef enum logic [2:0] {
    ST_IDLE, ST_DEC, ST_TREND, ST_SCAN, ST_DECIDE, ST_PUMP, ST_MASK, ST_DONE
  } state_t;

endpackage

// ----- rtl/multizone_heating_thermostat.sv -----
// Sequencing: a tick request is taken in IDLE and walks DEC, TREND, SCAN, DECIDE, PUMP and
//   MASK before its result is held in DONE; other requests go straight to MASK. The sequencer
//   walks one zone per cycle in each pass; SCAN, PUMP and MASK share one compare unit.
// Flow: one request at a time; ready again the cycle after the result is taken.
// Reset (rst, synchronous): all zone settings and control state return to defaults.
module multizone_heating_thermostat (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mzht_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output mzht_pkg::out_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mzht_pkg::*;

  // configuration
  logic [2:0] circuit_zone;
  logic [5:0] pump_zone_mask;
  logic [15:0] life_limit;

  // state
  logic relay_state, circuit_state, pump_state, bump_pending, bumped_flag;
  logic [15:0] run_ticks;
  logic zone_heat [ZONES];
  logic signed [15:0] zone_target [ZONES];
  logic signed [15:0] zone_tolerance [ZONES];
  logic signed [15:0] zone_temp [ZONES];
  logic [15:0] zone_life [ZONES];
  logic signed [15:0] hist [4];

  state_t state, state_next;
  logic [ZW-1:0] idx;
  logic any_rep, warm, cold, pneed, toggled;
  logic [2:0] reason;
  logic [5:0] online;

  logic has_circ;
  assign has_circ = circuit_zone < ZW'(ZONES);

  // shared per-zone unit, addressed by idx
  logic [15:0] half_life;
  logic s_online, s_offline, s_obs, normal, active;
  logic signed [17:0] t, tg, tl, hi_lim, lo_lim;
  logic le_hi, lt_lo;
  logic [2:0] idx3;
  assign idx3 = 3'(idx);
  assign half_life = life_limit >> 1;
  assign s_online = zone_life[idx] > half_life;
  assign s_obs = zone_life[idx] == 16'd0;
  assign s_offline = !s_online && !s_obs;
  assign normal = !(has_circ && idx3 == circuit_zone);
  assign active = normal && !s_offline && zone_heat[idx];
  assign t = 18'(zone_temp[idx]);
  assign tg = 18'(zone_target[idx]);
  assign tl = 18'(zone_tolerance[idx]);
  assign hi_lim = tg + tl;
  assign lo_lim = tg - tl;
  assign le_hi = t <= hi_lim;
  assign lt_lo = t < lo_lim;

  // circuit zone view
  logic [ZW-1:0] cz;
  logic c_live, rising, idle, c_hot, c_cold_ok;
  logic signed [15:0] ct;
  logic signed [17:0] drop;
  assign cz = ZW'(circuit_zone);
  assign ct = zone_temp[cz];
  assign c_live = has_circ && zone_life[cz] != 16'd0 && zone_heat[cz];
  assign rising = c_live && hist[3] < hist[2] && hist[2] < hist[1] &&
                  hist[1] < hist[0] && hist[0] < ct;
  assign drop = 18'(hist[0]) - 18'(ct);
  assign idle = c_live && ((hist[3] >= hist[2] && hist[2] >= hist[1] &&
                hist[1] >= hist[0] && hist[0] >= ct) || drop > CIRCUIT_DROP);
  assign c_hot = c_live && ct >= zone_tolerance[cz];
  assign c_cold_ok = !c_live || ct <= zone_target[cz];

  logic last;
  assign last = idx == ZW'(ZONES - 1);

  assign in_ready = state == ST_IDLE;
  assign out_valid = state == ST_DONE;
  always_comb begin
    out_data.heater_relay = relay_state;
    out_data.circuit_heating = circuit_state;
    out_data.water_pump = pump_state;
    out_data.bump_run = bumped_flag;
    out_data.switch_reason = reason;
    out_data.online_mask = online;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = (in_data.func == FN_TICK) ? ST_DEC : ST_MASK;
      ST_DEC: if (last) state_next = ST_TREND;
      ST_TREND: state_next = ST_SCAN;
      ST_SCAN: if (last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_PUMP;
      ST_PUMP: if (last) state_next = ST_MASK;
      ST_MASK: if (last) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      circuit_zone <= 3'd6;
      pump_zone_mask <= 6'd0;
      life_limit <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CIRCUIT: circuit_zone <= cfg_wdata[2:0];
        CFG_PUMP: pump_zone_mask <= cfg_wdata[5:0];
        CFG_LIFE: life_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // datapath and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
      circuit_state <= 1'b0;
      pump_state <= 1'b0;
      bump_pending <= 1'b0;
      bumped_flag <= 1'b0;
      run_ticks <= 16'd0;
      idx <= '0;
      reason <= RS_NONE;
      online <= '0;
      any_rep <= 1'b0; warm <= 1'b1; cold <= 1'b0; pneed <= 1'b0; toggled <= 1'b0;
      for (int z = 0; z < ZONES; z++) begin
        zone_heat[z] <= 1'b0;
        zone_target[z] <= DEFAULT_TARGET;
        zone_tolerance[z] <= DEFAULT_TOLERANCE;
        zone_temp[z] <= NO_TEMP;
        zone_life[z] <= DEFAULT_LIFE;
      end
      for (int h = 0; h < 4; h++) hist[h] <= NO_TEMP;
    end else begin
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          reason <= RS_NONE;
          online <= '0;
          any_rep <= 1'b0; warm <= 1'b1; cold <= 1'b0; pneed <= 1'b0; toggled <= 1'b0;
          if (in_valid) begin
            if (in_data.func == FN_TICK) begin
              if (run_ticks != 16'hFFFF) run_ticks <= run_ticks + 16'd1;
            end else if (in_data.func == FN_BUMP) begin
              bump_pending <= 1'b1;
            end else if (in_data.func <= FN_TOL && in_data.zone < ZW'(ZONES)) begin
              unique case (in_data.func)
                FN_READ: begin
                  if (in_data.reading != NO_TEMP)
                    zone_life[ZW'(in_data.zone)] <= life_limit;
                  if (has_circ && in_data.zone == circuit_zone) begin
                    hist[3] <= hist[2]; hist[2] <= hist[1]; hist[1] <= hist[0];
                    hist[0] <= zone_temp[ZW'(in_data.zone)];
                  end
                  zone_temp[ZW'(in_data.zone)] <= in_data.reading;
                end
                FN_MODE: zone_heat[ZW'(in_data.zone)] <= in_data.heat_mode;
                FN_SETP: zone_target[ZW'(in_data.zone)] <= in_data.setpoint;
                FN_TOL: zone_tolerance[ZW'(in_data.zone)] <= in_data.band;
                default: ;
              endcase
            end
          end
        end
        ST_DEC: begin
          if (zone_life[idx] != 16'd0) zone_life[idx] <= zone_life[idx] - 16'd1;
          idx <= last ? '0 : idx + ZW'(1);
        end
        ST_TREND: begin
          if (!circuit_state && rising) circuit_state <= 1'b1;
          else if (circuit_state && idle) begin
            circuit_state <= 1'b0;
            toggled <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (normal && !s_obs) any_rep <= 1'b1;
          if (active && le_hi) warm <= 1'b0;
          if (active && lt_lo) cold <= 1'b1;
          idx <= last ? '0 : idx + ZW'(1);
        end
        ST_DECIDE: begin
          if (relay_state) begin
            priority if (!any_rep) reason <= RS_OFF_NOSENS;
            else if (c_hot) reason <= RS_OFF_HOT;
            else if (toggled) reason <= RS_OFF_IDLE;
            else if (bumped_flag && run_ticks > BUMP_LIMIT) reason <= RS_OFF_LIMIT;
            else if (!bumped_flag && warm) reason <= RS_OFF_WARM;
            if (!any_rep || c_hot || toggled || run_ticks > BUMP_LIMIT)
              bumped_flag <= 1'b0;
            if (!any_rep || c_hot || toggled || (bumped_flag && run_ticks > BUMP_LIMIT) ||
                (!bumped_flag && warm)) begin
              relay_state <= 1'b0;
              run_ticks <= 16'd0;
            end
          end else if (c_cold_ok) begin
            if (cold) reason <= RS_ON_COLD;
            else if (bump_pending) begin
              reason <= RS_ON_BUMP;
              bumped_flag <= 1'b1;
            end
            if (cold || bump_pending) begin
              relay_state <= 1'b1;
              run_ticks <= 16'd0;
            end
          end
        end
        ST_PUMP: begin
          logic p;
          p = pneed || (idx3 < 3'd6 && pump_zone_mask[idx3] && !s_obs &&
              zone_heat[idx] && normal && le_hi);
          pneed <= p;
          if (last) begin
            if (relay_state) pump_state <= p || bumped_flag;
            bump_pending <= 1'b0;
          end
          idx <= last ? '0 : idx + ZW'(1);
        end
        ST_MASK: begin
          if (idx3 < 3'd6 && s_online) online[idx3] <= 1'b1;
          idx <= last ? '0 : idx + ZW'(1);
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

// ----- bench/thermostat_checker.sv -----
`timescale 1ns / 100ps

module thermostat_checker
  import mzht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  output int fails,
  output int pending,
  output int checked
);

  localparam int SNS_ONLINE = 0;
  localparam int SNS_OFFLINE = 1;
  localparam int SNS_OBSOLETE = 2;

  // register copies
  int unsigned circ_zone, pump_mask, lifetime;

  // control state
  bit relay, circ_on, pump_on, bump_req, bump_run;
  int unsigned run_len;
  bit heat[ZONES];
  int target[ZONES], tolerance[ZONES], temp[ZONES];
  int unsigned life[ZONES];
  int hist[4];

  out_t status_q[$];

  function automatic int sensor(int z);
    if (life[z] > lifetime / 2) return SNS_ONLINE;
    if (life[z] > 0) return SNS_OFFLINE;
    return SNS_OBSOLETE;
  endfunction

  function automatic bit has_circ();
    return circ_zone < ZONES;
  endfunction

  function automatic bit circ_live();
    if (!has_circ()) return 0;
    return sensor(circ_zone) != SNS_OBSOLETE && heat[circ_zone];
  endfunction

  function automatic bit plain_zone(int z);
    return !(has_circ() && z == circ_zone);
  endfunction

  function automatic bit active(int z);
    return plain_zone(z) && sensor(z) != SNS_OFFLINE && heat[z];
  endfunction

  // relay decision made on every tick
  function automatic logic [2:0] run_tick();
    logic [2:0] why;
    bit went_idle, cur_t, rising, falling, reporting, warm, cold, need;
    int t;
    why = RS_NONE;
    went_idle = 0;
    if (run_len < 65535) run_len++;
    for (int z = 0; z < ZONES; z++) if (life[z] > 0) life[z]--;

    t = has_circ() ? temp[circ_zone] : 0;
    rising = circ_live() && hist[3] < hist[2] && hist[2] < hist[1] &&
             hist[1] < hist[0] && hist[0] < t;
    falling = circ_live() && ((hist[3] >= hist[2] && hist[2] >= hist[1] &&
              hist[1] >= hist[0] && hist[0] >= t) || (hist[0] - t > 5));
    if (!circ_on && rising) circ_on = 1;
    else if (circ_on && falling) begin
      circ_on = 0;
      went_idle = 1;
    end

    reporting = 0;
    warm = 1;
    cold = 0;
    for (int z = 0; z < ZONES; z++) begin
      if (plain_zone(z) && sensor(z) != SNS_OBSOLETE) reporting = 1;
      if (active(z) && temp[z] <= target[z] + tolerance[z]) warm = 0;
      if (active(z) && temp[z] < target[z] - tolerance[z]) cold = 1;
    end

    if (relay) begin
      if (!reporting) why = RS_OFF_NOSENS;
      else if (circ_live() && temp[circ_zone] >= tolerance[circ_zone]) why = RS_OFF_HOT;
      else if (went_idle) why = RS_OFF_IDLE;
      if (why != RS_NONE) bump_run = 0;
      else if (bump_run) begin
        if (run_len > 120) begin
          why = RS_OFF_LIMIT;
          bump_run = 0;
        end
      end else if (warm) why = RS_OFF_WARM;
      if (why != RS_NONE) begin
        relay = 0;
        run_len = 0;
      end
    end else if (!circ_live() || temp[circ_zone] <= target[circ_zone]) begin
      if (cold) why = RS_ON_COLD;
      else if (bump_req) begin
        why = RS_ON_BUMP;
        bump_run = 1;
      end
      if (why != RS_NONE) begin
        relay = 1;
        run_len = 0;
      end
    end

    if (relay) begin
      need = 0;
      for (int z = 0; z < ZONES && z < 6; z++)
        if (pump_mask[z] && sensor(z) != SNS_OBSOLETE && heat[z] && plain_zone(z) &&
            temp[z] <= target[z] + tolerance[z]) need = 1;
      pump_on = need || bump_run;
    end
    bump_req = 0;
    return why;
  endfunction

  function automatic out_t thermostat_step(in_t d);
    out_t r;
    int z;
    r = '0;
    z = d.zone;
    if (d.func == FN_TICK) r.switch_reason = run_tick();
    else if (d.func == FN_BUMP) bump_req = 1;
    else if (d.func <= FN_TOL && z < ZONES) begin
      case (d.func)
        FN_READ: begin
          if (d.reading != NO_TEMP) life[z] = lifetime;
          if (has_circ() && z == circ_zone) begin
            hist[3] = hist[2];
            hist[2] = hist[1];
            hist[1] = hist[0];
            hist[0] = temp[z];
          end
          temp[z] = d.reading;
        end
        FN_MODE: heat[z] = d.heat_mode;
        FN_SETP: target[z] = d.setpoint;
        default: tolerance[z] = d.band;
      endcase
    end
    for (int k = 0; k < ZONES && k < 6; k++)
      if (sensor(k) == SNS_ONLINE) r.online_mask[k] = 1'b1;
    r.heater_relay = relay;
    r.circuit_heating = circ_on;
    r.water_pump = pump_on;
    r.bump_run = bump_run;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      fails = 0;
      checked = 0;
      circ_zone = 6;
      pump_mask = 0;
      lifetime = 10;
      {relay, circ_on, pump_on, bump_req, bump_run} = '0;
      run_len = 0;
      for (int z = 0; z < ZONES; z++) begin
        heat[z] = 0;
        target[z] = DEFAULT_TARGET;
        tolerance[z] = DEFAULT_TOLERANCE;
        temp[z] = NO_TEMP;
        life[z] = DEFAULT_LIFE;
      end
      for (int k = 0; k < 4; k++) hist[k] = NO_TEMP;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CIRCUIT: circ_zone = cfg_wdata[2:0];
          CFG_PUMP: pump_mask = cfg_wdata[5:0];
          CFG_LIFE: lifetime = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected status %p", $time, out_data);
        end else begin
          want = status_q.pop_front();
          checked++;
          if (want.heater_relay !== out_data.heater_relay ||
              want.circuit_heating !== out_data.circuit_heating ||
              want.water_pump !== out_data.water_pump ||
              want.bump_run !== out_data.bump_run ||
              want.switch_reason !== out_data.switch_reason ||
              want.online_mask !== out_data.online_mask) begin
            fails++;
            $display("%0t: status mismatch expected %p actual %p", $time, want, out_data);
          end
        end
      end
      if (in_valid && in_ready) status_q.push_back(thermostat_step(in_data));
    end
    pending = status_q.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mzht_pkg::*;

  localparam int IN_W = $bits(in_t);

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  int fails, pending, checked;
  int cycles = 0;
  int requests, writes, results;
  bit tx_idle, rx_idle;
  int circ_sel, circ_temp;
  bit circ_up;

  multizone_heating_thermostat uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  thermostat_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // random request with the addressed fields forced
  function automatic in_t req(logic [2:0] f, int z);
    in_t d;
    d = IN_W'({$urandom, $urandom});
    d.func = f;
    d.zone = 3'(z);
    return d;
  endfunction

  task automatic send(input in_t d);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    repeat (gap) @(negedge clk);
    in_data = d;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    requests++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_index = idx;
    cfg_wdata = 16'(val);
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    writes++;
  endtask

  task automatic send_reading(int z, int v);
    in_t d;
    d = req(FN_READ, z);
    d.reading = 16'(v);
    send(d);
  endtask

  task automatic send_setting(logic [2:0] f, int z, int v);
    in_t d;
    d = req(f, z);
    d.heat_mode = v[0];
    d.setpoint = 16'(v);
    d.band = 16'(v);
    send(d);
  endtask

  // random request shaped toward the thermostat's decision points
  function automatic in_t rand_req();
    in_t d;
    int p, z;
    p = $urandom_range(0, 99);
    z = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    if (p < 35) d = req(FN_TICK, z);
    else if (p < 65) begin
      d = req(FN_READ, z);
      if (z == circ_sel) begin
        d.reading = 16'(circ_temp);
        circ_temp += circ_up ? int'($urandom_range(1, 8)) : -int'($urandom_range(0, 8));
        if ($urandom_range(0, 6) == 0) circ_up = !circ_up;
      end else if ($urandom_range(0, 9) == 0) d.reading = NO_TEMP;
      else if ($urandom_range(0, 9) != 0) d.reading = 16'($urandom_range(150, 280));
    end else if (p < 70) d = req(FN_BUMP, z);
    else if (p < 80) begin
      d = req(FN_MODE, z);
      d.heat_mode = $urandom_range(0, 4) != 0;
    end else if (p < 88) begin
      d = req(FN_SETP, z);
      if ($urandom_range(0, 9) != 0) d.setpoint = 16'($urandom_range(180, 240));
    end else if (p < 96) begin
      d = req(FN_TOL, z);
      if ($urandom_range(0, 9) != 0)
        d.band = 16'((z == circ_sel) ? $urandom_range(150, 400) : $urandom_range(0, 30));
    end else d = req(3'($urandom_range(0, 7)), $urandom_range(0, 7));
    return d;
  endfunction

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    out_ready = 0;
    results = 0;
    rx_idle = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int gap;
      if (results == 150) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
      end
      if (results % 64 == 0) rx_idle = $urandom_range(0, 3) != 0;
      gap = rx_idle ? $urandom_range(0, 12) : 0;
      out_ready = 0;
      repeat (gap) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      results++;
      @(negedge clk);
    end
  end

  initial begin
    int life_v, n;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_CIRCUIT;
    cfg_wdata = '0;
    requests = 0;
    writes = 0;
    tx_idle = 1;
    circ_sel = ZONES;
    circ_temp = 200;
    circ_up = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes, ignored items, cold start and warm stop
    send(req(FN_TICK, 0));
    send_reading(0, 200);
    send_reading(5, 32767);
    send_reading(1, NO_TEMP);
    send_reading(6, 100);
    send_setting(FN_MODE, 0, 1);
    send_setting(FN_SETP, 0, -32768);
    send_setting(FN_TOL, 0, 32767);
    send_setting(FN_SETP, 7, 0);
    send_setting(FN_TOL, 6, -1);
    send(req(3'd6, 0));
    send(req(3'd7, 7));
    send(req(FN_BUMP, 3));
    send(req(FN_TICK, 0));
    send_setting(FN_MODE, 2, 1);
    send_reading(2, 100);
    send(req(FN_TICK, 0));
    send_reading(2, 300);
    send(req(FN_TICK, 0));
    send_setting(FN_SETP, 0, 32767);
    send_setting(FN_TOL, 0, -32768);
    send(req(FN_TICK, 0));
    send(req(FN_TICK, 0));

    // bump run held past its limit with no active zones
    write_reg(CFG_CIRCUIT, 7);
    write_reg(CFG_PUMP, 63);
    write_reg(CFG_LIFE, 20);
    for (int z = 0; z < ZONES; z++) send_setting(FN_MODE, z, 0);
    send(req(FN_TICK, 0));
    send(req(FN_BUMP, 0));
    for (int k = 0; k < 130; k++) begin
      if (k % 4 == 0) send_reading(k % ZONES, 210);
      send(req(FN_TICK, 0));
    end

    // random phases over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      tx_idle = ph % 3 != 2;
      circ_sel = (ph == 9) ? 0 : $urandom_range(0, 7);
      if (ph == 1) circ_sel = 6;
      case (ph)
        0: life_v = 1;
        4: life_v = 65535;
        7: life_v = 0;
        default: life_v = $urandom_range(3, 20);
      endcase
      write_reg(CFG_CIRCUIT, circ_sel);
      write_reg(CFG_PUMP, (ph == 2) ? 0 : (ph == 3) ? 63 : $urandom_range(0, 63));
      write_reg(CFG_LIFE, life_v);
      circ_temp = $urandom_range(150, 250);
      n = 38;
      for (int k = 0; k < n; k++) send(rand_req());
    end

    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    $display("tb: %0d requests, %0d register writes, %0d status results checked",
             requests, writes, checked);
    $display("tb: covered bump limit, cold/warm switching, circuit trends, sensor aging");
    if (fails == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mzht_pkg.sv
rtl/multizone_heating_thermostat.sv
bench/thermostat_checker.sv
bench/tb.sv
